// ----- sv/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the sorter RTL.
// Needs nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, active during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ----- sv/msis_pkg.sv -----
// msis_pkg: types and constants of the merge insertion sorter.
// No dependencies; used by the interfaces, the cell and the top level.
package msis_pkg;

    localparam int VALUE_W = 32;

    typedef logic [VALUE_W-1:0] value_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic   load;   // insert data into the chain
        logic   shift;  // move the chain one place toward cell 0
        value_t data;   // value being inserted
    } cell_ctrl_t;

endpackage

// ----- sv/msis_in_if.sv -----
// msis_in_if: input channel of the sorter (value plus end-of-set mark).
// Depends on msis_pkg.
interface msis_in_if
    import msis_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value_in;
    logic   end_of_set;

    modport source (output valid, output value_in, output end_of_set, input ready);
    modport sink   (input valid, input value_in, input end_of_set, output ready);
endinterface

// ----- sv/msis_out_if.sv -----
// msis_out_if: result channel of the sorter (sorted value and flags).
// Depends on msis_pkg.
interface msis_out_if
    import msis_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   final_result;
    logic   items_dropped;

    modport source (output valid, output sorted_value, output final_result,
                    output items_dropped, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input items_dropped, output ready);
endinterface

// ----- sv/msis_cell.sv -----
// msis_cell: one place of the sorted chain. Holds a value and a valid bit,
// inserts by comparing with the broadcast value, shifts toward cell 0 on output.
// Depends on msis_pkg.
module msis_cell
    import msis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     prev_value,
    input  logic       prev_valid,
    input  logic       prev_ins,
    input  value_t     next_value,
    input  logic       next_valid,
    output value_t     value,
    output logic       valid,
    output logic       ins
);

    value_t value_reg, value_next;
    logic   valid_reg, valid_next;

    // Insertion point lies at or before this cell
    assign ins = !valid_reg || (ctrl.data < value_reg);

    // Next value and valid bit
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.load)
        begin
            valid_next = valid_reg || prev_valid;
            if (ins)
            begin
                value_next = prev_ins ? prev_value : ctrl.data;
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- sv/merge_insertion_sorter_top.sv -----
// merge_insertion_sorter_top: sorter built as a chain of insertion cells.
// Depends on msis_pkg, msis_in_if, msis_out_if, msis_cell, assert_macros.svh.
//
// Usage:
//   items   : sink channel. Each transaction carries value_in and end_of_set.
//             A value accepted while the chain is not full is inserted into
//             the sorted chain in the cycle it is accepted, so values can be
//             accepted back to back. A transaction with end_of_set closes the set.
//   results : source channel. The set comes out in ascending order, one
//             transaction per cycle while ready is high; final_result marks
//             the largest value, items_dropped is 1 on every transaction of a
//             set in which values beyond MAX_ITEMS were discarded.
// Timing: the first result is valid the cycle after the end_of_set
//   transaction. Each cell makes a single compare on load, and the chain
//   shifts one place on output.
// items.ready is low while a set is being emitted. A stalled receiver holds
//   the chain and the current result unchanged.
// Reset clears the valid bits of all cells and the overflow flag; the block
//   is ready for a new set in the first cycle after reset.
module merge_insertion_sorter_top
    import msis_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    msis_in_if.sink    items,
    msis_out_if.source results
);

`include "assert_macros.svh"

    cell_ctrl_t           ctrl;
    value_t               cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] valid_vec;
    logic [MAX_ITEMS-1:0] ins_vec;
    logic                 emit_reg, emit_next;
    logic                 overflow_reg, overflow_next;
    logic                 in_acc, out_acc, full;

    // Handshakes
    assign full    = valid_vec[MAX_ITEMS-1];
    assign in_acc  = items.valid && items.ready;
    assign out_acc = results.valid && results.ready;

    assign ctrl.load  = in_acc && !full;
    assign ctrl.shift = out_acc;
    assign ctrl.data  = items.value_in;

    // Cell chain
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        value_t prev_value, next_value;
        logic   prev_valid, prev_ins, next_valid;

        if (i == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_valid = 1'b1;
            assign prev_ins   = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_valid = valid_vec[i-1];
            assign prev_ins   = ins_vec[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_value = cell_value[i+1];
            assign next_valid = valid_vec[i+1];
        end

        msis_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_ins   (prev_ins),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (valid_vec[i]),
            .ins        (ins_vec[i])
        );
    end

    // Load / emit control
    always_comb
    begin
        emit_next     = emit_reg;
        overflow_next = overflow_reg;
        if (in_acc && full)
        begin
            overflow_next = 1'b1;
        end
        if (in_acc && items.end_of_set)
        begin
            emit_next = 1'b1;
        end
        if (out_acc && results.final_result)
        begin
            emit_next     = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            emit_reg     <= emit_next;
            overflow_reg <= overflow_next;
        end
    end

    // Channel outputs
    assign items.ready           = !emit_reg;
    assign results.valid         = emit_reg && valid_vec[0];
    assign results.sorted_value  = cell_value[0];
    assign results.final_result  = !valid_vec[1];
    assign results.items_dropped = overflow_reg;

    // Checks
    `ASSERT_CLK_RST(a_no_overlap, clk, rst_n, results.valid |-> !items.ready, "load while emitting")
    `ASSERT_CLK_RST(a_empty_after_set, clk, rst_n, (out_acc && results.final_result) |=> !valid_vec[0], "chain not empty after last result")
    `ASSERT_CLK_RST(a_valid_prefix, clk, rst_n, (valid_vec & (valid_vec + {{(MAX_ITEMS-1){1'b0}}, 1'b1})) == '0, "valid cells not contiguous")
    `ASSERT_CLK_RST(a_emit_start, clk, rst_n, $rose(emit_reg) |-> $past(in_acc && items.end_of_set), "emit without end of set")

endmodule
